// File: rtl/core/tmn_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the tree token mutex node.
package tmn_pkg;

    localparam int ID_W           = 4;
    localparam int NODE_COUNT     = 16;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int GQ_DEPTH       = 4;
    localparam int GQ_AW          = 2;
    localparam int GQ_CW          = 3;

    typedef enum logic [1:0] {
        CMD_ENTER   = 2'd0,
        CMD_REQUEST = 2'd1,
        CMD_TOKEN   = 2'd2,
        CMD_EXIT    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_TOKEN   = 2'd0,
        KIND_REQUEST = 2'd1,
        KIND_GRANT   = 2'd2
    } t_kind;

    typedef enum logic {
        CFG_OWN_ID      = 1'b0,
        CFG_INIT_HOLDER = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_kind             kind;
        logic [ID_W-1:0]   target;
    } t_msg;

    // results of one event: slot 0 always used, slot 1 when two is set
    typedef struct packed {
        logic  two;
        logic  ovf;
        t_msg  m0;
        t_msg  m1;
    } t_grp;

endpackage

// File: rtl/core/tmn_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module tmn_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [$clog2(DEPTH)-1:0]        i_waddr,
    input  logic [WIDTH-1:0]                i_wdata,
    input  logic [$clog2(DEPTH)-1:0]        i_raddr,
    output logic [WIDTH-1:0]                o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/tmn_front.sv
`timescale 1ns / 1ps
// Event front end: holder/flag state, requester queue, result group build.
module tmn_front #(
    parameter int QUEUE_DEPTH = tmn_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  tmn_pkg::t_cfg_idx           i_cfg_idx,
    input  logic [tmn_pkg::ID_W-1:0]    i_cfg_data,
    input  logic                        i_valid,
    input  tmn_pkg::t_cmd               i_cmd,
    input  logic [tmn_pkg::ID_W-1:0]    i_sender,
    output logic                        o_ready,
    input  logic                        i_full,
    output logic                        o_push,
    output tmn_pkg::t_grp               o_grp
);

    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int SW    = CW + 1;
    localparam int IDW   = tmn_pkg::ID_W;

    logic [IDW-1:0] r_own, n_own;
    logic [IDW-1:0] r_holder, n_holder;
    logic           r_in_use, n_in_use;
    logic           r_asked, n_asked;
    logic [AW-1:0]  r_head, n_head;
    logic [CW-1:0]  r_count, n_count;
    logic           r_fwd_hit, n_fwd_hit;
    logic [IDW-1:0] r_fwd_data;

    logic           acc, is_push, ignore, full, do_push, dropped;
    logic [IDW-1:0] push_id, ram_q, head_val, holder1, holder2;
    logic           in_use1, in_use2, asked2, asked3, pop, grant, req;
    logic [CW-1:0]  count1, count2;
    logic [AW-1:0]  head2, waddr, raddr, head_inc;
    logic [SW-1:0]  tail_sum;

    assign o_ready = !i_full;
    assign acc     = i_valid && o_ready;

    always_comb begin
        is_push = 1'b0;
        ignore  = 1'b0;
        push_id = r_own;
        unique case (i_cmd)
            tmn_pkg::CMD_ENTER: begin
                is_push = 1'b1;
            end
            tmn_pkg::CMD_REQUEST: begin
                is_push = 1'b1;
                push_id = i_sender;
                ignore  = 32'(i_sender) >= 32'(tmn_pkg::NODE_COUNT);
            end
            tmn_pkg::CMD_TOKEN: begin
            end
            tmn_pkg::CMD_EXIT: begin
            end
            default: begin
            end
        endcase
    end

    assign full     = r_count == CW'(QUEUE_DEPTH);
    assign do_push  = is_push && !full && !ignore;
    assign dropped  = is_push && full;

    assign tail_sum = SW'(r_head) + SW'(r_count);
    assign waddr    = (tail_sum >= SW'(QUEUE_DEPTH)) ? AW'(tail_sum - SW'(QUEUE_DEPTH))
                                                     : AW'(tail_sum);
    assign head_inc = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;

    assign head_val = (r_count == '0) ? push_id : (r_fwd_hit ? r_fwd_data : ram_q);

    assign holder1  = (i_cmd == tmn_pkg::CMD_TOKEN) ? r_own : r_holder;
    assign in_use1  = (i_cmd == tmn_pkg::CMD_EXIT) ? 1'b0 : r_in_use;
    assign count1   = r_count + CW'(do_push);

    assign pop      = holder1 == r_own && !in_use1 && count1 != '0;
    assign grant    = pop && head_val == r_own;
    assign holder2  = pop ? head_val : holder1;
    assign asked2   = pop ? 1'b0 : r_asked;
    assign in_use2  = grant ? 1'b1 : in_use1;
    assign count2   = count1 - CW'(pop);
    assign head2    = pop ? head_inc : r_head;

    assign req      = holder2 != r_own && count2 != '0 && !asked2;
    assign asked3   = req ? 1'b1 : asked2;

    assign raddr    = (acc && !ignore) ? head2 : r_head;

    always_comb begin
        n_own     = r_own;
        n_holder  = r_holder;
        n_in_use  = r_in_use;
        n_asked   = r_asked;
        n_head    = r_head;
        n_count   = r_count;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tmn_pkg::CFG_OWN_ID:      n_own    = i_cfg_data;
                tmn_pkg::CFG_INIT_HOLDER: n_holder = i_cfg_data;
                default: begin
                end
            endcase
        end
        if (acc && !ignore) begin
            n_holder = holder2;
            n_in_use = in_use2;
            n_asked  = asked3;
            n_head   = head2;
            n_count  = count2;
        end
        n_fwd_hit = acc && do_push && waddr == raddr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own     <= '0;
            r_holder  <= '0;
            r_in_use  <= 1'b0;
            r_asked   <= 1'b0;
            r_head    <= '0;
            r_count   <= '0;
            r_fwd_hit <= 1'b0;
        end else begin
            r_own     <= n_own;
            r_holder  <= n_holder;
            r_in_use  <= n_in_use;
            r_asked   <= n_asked;
            r_head    <= n_head;
            r_count   <= n_count;
            r_fwd_hit <= n_fwd_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= push_id;
    end

    tmn_ram #(
        .WIDTH (IDW),
        .DEPTH (QUEUE_DEPTH)
    ) u_req_ram (
        .i_clk   (i_clk),
        .i_we    (acc && do_push),
        .i_waddr (waddr),
        .i_wdata (push_id),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    // pack the event's results; a lone request sits in slot 0
    always_comb begin
        o_grp.ovf       = dropped;
        o_grp.two       = pop && req;
        o_grp.m1.kind   = tmn_pkg::KIND_REQUEST;
        o_grp.m1.target = holder2;
        if (pop) begin
            o_grp.m0.kind   = grant ? tmn_pkg::KIND_GRANT : tmn_pkg::KIND_TOKEN;
            o_grp.m0.target = head_val;
        end else begin
            o_grp.m0.kind   = tmn_pkg::KIND_REQUEST;
            o_grp.m0.target = holder2;
        end
    end

    assign o_push = acc && !ignore && (pop || req);

endmodule

// File: rtl/core/tmn_gq.sv
`timescale 1ns / 1ps
// Short queue of result groups between the front end and the output side.
module tmn_gq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tmn_pkg::t_grp   i_grp,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output tmn_pkg::t_grp   o_grp
);

    localparam int AW = tmn_pkg::GQ_AW;
    localparam int CW = tmn_pkg::GQ_CW;

    tmn_pkg::t_grp  r_mem [tmn_pkg::GQ_DEPTH];
    logic [AW-1:0]  r_wp, n_wp;
    logic [AW-1:0]  r_rp, n_rp;
    logic [CW-1:0]  r_cnt, n_cnt;

    assign o_full  = r_cnt == CW'(tmn_pkg::GQ_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_grp   = r_mem[r_rp];

    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + CW'(i_push) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_grp;
        end
    end

endmodule

// File: rtl/core/tmn_back.sv
`timescale 1ns / 1ps
// Output side: splits each result group into one or two beats.
module tmn_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  tmn_pkg::t_grp               i_grp,
    output logic                        o_pop,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [7:0]                  o_m_tdata,
    output logic [1:0]                  o_m_tuser,
    output logic                        o_m_tlast
);

    logic          r_sel, n_sel;
    logic          beat;
    tmn_pkg::t_msg msg;

    assign o_m_tvalid = !i_empty;
    assign beat       = o_m_tvalid && i_m_tready;
    assign msg        = r_sel ? i_grp.m1 : i_grp.m0;

    assign o_m_tdata  = {3'b000, i_grp.ovf, msg.target};
    assign o_m_tuser  = msg.kind;
    assign o_m_tlast  = r_sel || !i_grp.two;
    assign o_pop      = beat && o_m_tlast;

    always_comb begin
        n_sel = r_sel;
        if (beat) begin
            n_sel = !o_m_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
        end else begin
            r_sel <= n_sel;
        end
    end

endmodule

// File: rtl/core/tree_token_mutex_node.sv
`timescale 1ns / 1ps
// Tree token mutex node top level: event stream in, message stream out.
// Throughput: one event per cycle while the result-group queue has room;
// an event giving two messages occupies the output for two beats.
// The first message of an event is offered from the result-group queue once earlier groups have left it.
// Reset (sync, active low): flags, counts and holder cleared; the requester
// RAM is not cleared and needs no clearing pass.
module tree_token_mutex_node #(
    parameter int QUEUE_DEPTH = tmn_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [tmn_pkg::ID_W-1:0]    i_cfg_data,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [7:0]                  i_s_tdata,  // [3:0] sender_id
    input  logic [1:0]                  i_s_tuser,  // [1:0] command
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [7:0]                  o_m_tdata,  // [3:0] target_id, [4] overflow
    output logic [1:0]                  o_m_tuser,  // [1:0] msg_kind
    output logic                        o_m_tlast
);

    logic          gq_full, gq_empty, gq_push, gq_pop;
    tmn_pkg::t_grp grp_in, grp_out;
    logic [3:0]    unused_pad;

    assign unused_pad = i_s_tdata[7:4];

    tmn_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (tmn_pkg::t_cfg_idx'(i_cfg_idx)),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_tvalid),
        .i_cmd      (tmn_pkg::t_cmd'(i_s_tuser)),
        .i_sender   (i_s_tdata[3:0]),
        .o_ready    (o_s_tready),
        .i_full     (gq_full),
        .o_push     (gq_push),
        .o_grp      (grp_in)
    );

    tmn_gq u_gq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (gq_push),
        .i_grp   (grp_in),
        .o_full  (gq_full),
        .i_pop   (gq_pop),
        .o_empty (gq_empty),
        .o_grp   (grp_out)
    );

    tmn_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (gq_empty),
        .i_grp      (grp_out),
        .o_pop      (gq_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the tree token mutex node: predicted message stream vs DUT.
module tb;

    localparam int ID_W          = tmn_pkg::ID_W;
    localparam int NODE_COUNT    = tmn_pkg::NODE_COUNT;
    localparam int DEPTH         = tmn_pkg::QUEUE_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 170;

    typedef struct {
        tmn_pkg::t_kind  kind;
        logic [ID_W-1:0] target;
        logic            ovf;
        logic            last;
    } t_node_msg;

    class t_token_node_mirror;
        logic [ID_W-1:0] own_id;
        logic [ID_W-1:0] holder;
        logic            in_use;
        logic            asked;
        logic [ID_W-1:0] waiters[$];
        t_node_msg       due_msgs[$];
        int              mismatches;

        function new();
            own_id     = '0;
            holder     = '0;
            in_use     = 1'b0;
            asked      = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(tmn_pkg::t_cfg_idx idx, logic [ID_W-1:0] value);
            if (idx == tmn_pkg::CFG_OWN_ID) begin
                own_id = value;
            end else begin
                holder = value;
            end
        endfunction

        function void accept_event(tmn_pkg::t_cmd cmd, logic [ID_W-1:0] sender);
            t_node_msg batch[$];
            t_node_msg m;
            logic      dropped;
            dropped = 1'b0;
            case (cmd)
                tmn_pkg::CMD_ENTER: begin
                    if (waiters.size() >= DEPTH) dropped = 1'b1;
                    else waiters.push_back(own_id);
                end
                tmn_pkg::CMD_REQUEST: begin
                    if (int'(sender) >= NODE_COUNT) return;
                    if (waiters.size() >= DEPTH) dropped = 1'b1;
                    else waiters.push_back(sender);
                end
                tmn_pkg::CMD_TOKEN: holder = own_id;
                default:   in_use = 1'b0;
            endcase
            // hand the token on, or take the critical section
            if (holder == own_id && !in_use && waiters.size() > 0) begin
                holder = waiters.pop_front();
                asked  = 1'b0;
                if (holder == own_id) begin
                    in_use   = 1'b1;
                    m.kind   = tmn_pkg::KIND_GRANT;
                    m.target = own_id;
                end else begin
                    m.kind   = tmn_pkg::KIND_TOKEN;
                    m.target = holder;
                end
                batch.push_back(m);
            end
            // still waiting: ask towards the token
            if (holder != own_id && waiters.size() > 0 && !asked) begin
                asked    = 1'b1;
                m.kind   = tmn_pkg::KIND_REQUEST;
                m.target = holder;
                batch.push_back(m);
            end
            foreach (batch[k]) begin
                batch[k].ovf  = dropped;
                batch[k].last = (k == batch.size() - 1);
                due_msgs.push_back(batch[k]);
            end
        endfunction

        function void check_message(tmn_pkg::t_kind kind, logic [ID_W-1:0] target,
                                    logic ovf, logic last);
            t_node_msg want;
            if (due_msgs.size() == 0) begin
                $display("%0t: unexpected beat kind %0d target %0d ovf %0d last %0d",
                         $time, kind, target, ovf, last);
                mismatches++;
                return;
            end
            want = due_msgs.pop_front();
            if (kind !== want.kind || target !== want.target || ovf !== want.ovf ||
                last !== want.last) begin
                $display("%0t: expected kind %0d target %0d ovf %0d last %0d, ",
                         $time, want.kind, want.target, want.ovf, want.last,
                         "got kind %0d target %0d ovf %0d last %0d",
                         kind, target, ovf, last);
                mismatches++;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [ID_W-1:0]  i_cfg_data;
    logic             i_s_tvalid;
    logic             o_s_tready;
    logic [7:0]       i_s_tdata;   // [3:0] sender_id
    logic [1:0]       i_s_tuser;   // [1:0] command
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [7:0]       o_m_tdata;   // [3:0] target_id, [4] overflow
    logic [1:0]       o_m_tuser;   // [1:0] msg_kind
    logic             o_m_tlast;

    t_token_node_mirror mirror = new();
    int                 sender_idle = 0;
    int                 recv_stall  = 0;
    int                 cycles      = 0;

    tree_token_mutex_node DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            mirror.check_message(tmn_pkg::t_kind'(o_m_tuser), o_m_tdata[3:0],
                                 o_m_tdata[4], o_m_tlast);
    end

    task automatic send_event(input tmn_pkg::t_cmd cmd, input logic [ID_W-1:0] sender);
        while ($urandom_range(99) < sender_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {4'b0000, sender};
        do @(posedge i_clk); while (!o_s_tready);
        mirror.accept_event(cmd, sender);
    endtask

    // wait for every due message, then for any event still in flight
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (mirror.due_msgs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [ID_W-1:0] own, input logic [ID_W-1:0] start);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= tmn_pkg::CFG_OWN_ID;
        i_cfg_data <= own;
        @(posedge i_clk);
        mirror.write_reg(tmn_pkg::CFG_OWN_ID, own);
        i_cfg_idx  <= tmn_pkg::CFG_INIT_HOLDER;
        i_cfg_data <= start;
        @(posedge i_clk);
        mirror.write_reg(tmn_pkg::CFG_INIT_HOLDER, start);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_random(input int count, input bit flood);
        tmn_pkg::t_cmd   cmd;
        logic [ID_W-1:0] sender;
        int              r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (mirror.in_use && r < 30) begin
                cmd = tmn_pkg::CMD_EXIT;
            end else if (mirror.asked && mirror.holder != mirror.own_id &&
                         r < (flood ? 8 : 60)) begin
                cmd = tmn_pkg::CMD_TOKEN;
            end else begin
                r = $urandom_range(99);
                if (r < (flood ? 70 : 40)) cmd = tmn_pkg::CMD_REQUEST;
                else if (r < (flood ? 88 : 70)) cmd = tmn_pkg::CMD_ENTER;
                else if (r < (flood ? 93 : 85)) cmd = tmn_pkg::CMD_TOKEN;
                else cmd = tmn_pkg::CMD_EXIT;
            end
            sender = ($urandom_range(9) == 0) ? mirror.own_id : ID_W'($urandom_range(15));
            send_event(cmd, sender);
            if ($urandom_range(199) == 0) settle();
        end
    endtask

    initial begin
        logic [ID_W-1:0] own;
        logic [ID_W-1:0] start;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= tmn_pkg::CFG_OWN_ID;
        i_cfg_data <= '0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: token held here
        configure(4'd5, 4'd5);
        send_event(tmn_pkg::CMD_ENTER, 4'd0);
        send_event(tmn_pkg::CMD_REQUEST, 4'd3);
        send_event(tmn_pkg::CMD_TOKEN, 4'd15);    // token while already held
        send_event(tmn_pkg::CMD_EXIT, 4'd0);
        send_event(tmn_pkg::CMD_EXIT, 4'd15);     // exit when not in use
        send_event(tmn_pkg::CMD_REQUEST, 4'd5);   // own id queued as a neighbour
        send_event(tmn_pkg::CMD_ENTER, 4'd9);
        send_event(tmn_pkg::CMD_TOKEN, 4'd0);
        send_event(tmn_pkg::CMD_REQUEST, 4'd15);
        send_event(tmn_pkg::CMD_EXIT, 4'd0);      // exit grants the critical section again to the queued own id
        // fill the queue, then one dropped push
        for (int i = 0; i < DEPTH; i++)
            send_event(tmn_pkg::CMD_REQUEST, (i == 0) ? 4'd0 : ID_W'($urandom_range(15)));
        settle();
        // reconfigure with the queue still full: this push is dropped, but no message carries the flag
        configure(4'd5, 4'd5);
        send_event(tmn_pkg::CMD_REQUEST, 4'd10);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin sender_idle = 0;  recv_stall = 0;  end
                1: begin sender_idle = 77; recv_stall = 0;  end
                2: begin sender_idle = 0;  recv_stall = 77; end
                default: begin sender_idle = 31; recv_stall = 31; end
            endcase
            case (p)
                0: begin own = 4'd0;  start = 4'd0;  end
                1: begin own = 4'd15; start = 4'd15; end
                2: begin own = 4'd15; start = 4'd0;  end
                3: begin own = 4'd0;  start = 4'd15; end
                default: begin
                    own   = ID_W'($urandom_range(15));
                    start = $urandom_range(1) ? own : ID_W'($urandom_range(15));
                end
            endcase
            configure(own, start);
            run_random(PHASE_ITEMS, p[0]);
            settle();
        end

        settle();
        if (mirror.mismatches == 0 && mirror.due_msgs.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule

// File: files.f
rtl/core/tmn_pkg.sv
rtl/core/tmn_ram.sv
rtl/core/tmn_front.sv
rtl/core/tmn_gq.sv
rtl/core/tmn_back.sv
rtl/core/tree_token_mutex_node.sv
bench/tb.sv
